// File: src/button_debounce_hold_detector_macros.svh
// Assertion helpers for the checker file.
`ifndef BUTTON_DEBOUNCE_HOLD_DETECTOR_MACROS_SVH
`define BUTTON_DEBOUNCE_HOLD_DETECTOR_MACROS_SVH

// Checked only outside reset.
`define BDH_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("bdh assertion failed");

// Checked during reset as well.
`define BDH_ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("bdh reset assertion failed");

`endif

// File: src/bdh_pkg.sv
package bdh_pkg;

  localparam int CountWidth = 16;
  localparam int CfgWidth   = 16;
  localparam int CfgIndexW  = 2;

  localparam logic [CountWidth-1:0] CountMax = {CountWidth{1'b1}};

  localparam logic [CfgIndexW-1:0] RegDebounceTicks = 2'd0;
  localparam logic [CfgIndexW-1:0] RegHoldTicks     = 2'd1;
  localparam logic [CfgIndexW-1:0] RegInvertLevel   = 2'd2;

  localparam logic [15:0] DebounceTicksReset = 16'd20;
  localparam logic [15:0] HoldTicksReset     = 16'd1000;

  typedef enum logic [2:0] {
    ST_IDLE       = 3'd0,
    ST_PRESS_DB   = 3'd1,
    ST_PRESSED    = 3'd2,
    ST_HELD       = 3'd3,
    ST_RELEASE_DB = 3'd4
  } state_t;

  typedef enum logic [1:0] {
    EV_NONE     = 2'd0,
    EV_PRESSED  = 2'd1,
    EV_HELD     = 2'd2,
    EV_RELEASED = 2'd3
  } event_t;

  typedef struct packed {
    event_t ev;
    logic   pressed;
  } result_t;

  function automatic logic [CountWidth-1:0] sat_inc(input logic [CountWidth-1:0] v);
    return (v == CountMax) ? CountMax : v + 1'b1;
  endfunction

endpackage

// File: src/button_debounce_hold_detector.sv
// Channel   Handshake                 Payload
// input     in_valid / in_stall       pin_level
// output    out_valid / out_stall     event_code, btn_down
// config    cfg_write                 cfg_index, cfg_data
//
// One tick per cycle while in_stall is low, one result word per tick, registered at the output.
// State and counters update in the cycle a tick is accepted.
// A two-deep output (result register plus skid) keeps input flowing while
// the sink stalls until the skid fills; in_stall rises only when both are full.
// rst (synchronous) restores idle state and register defaults.
module button_debounce_hold_detector (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [bdh_pkg::CfgIndexW-1:0]     cfg_index,
  input  logic [bdh_pkg::CfgWidth-1:0]      cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              pin_level,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [1:0]                        event_code,
  output logic                              btn_down
);

  logic [15:0] debounce_ticks;
  logic [15:0] hold_ticks;
  logic        invert_level;

  bdh_pkg::state_t                    state, state_next;
  logic [bdh_pkg::CountWidth-1:0]     debounce_count, debounce_count_next;
  logic [bdh_pkg::CountWidth-1:0]     hold_count, hold_count_next;
  logic                               pressed_flag, pressed_flag_next;
  bdh_pkg::event_t                    ev;

  bdh_pkg::result_t result, out_word, skid_word;
  logic             skid_valid;
  logic             in_acc, out_take;
  logic             active;
  logic [bdh_pkg::CountWidth-1:0] db_inc, hold_inc;
  logic             db_done, hold_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ticks <= bdh_pkg::DebounceTicksReset;
      hold_ticks     <= bdh_pkg::HoldTicksReset;
      invert_level   <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        bdh_pkg::RegDebounceTicks: debounce_ticks <= cfg_data[15:0];
        bdh_pkg::RegHoldTicks:     hold_ticks     <= cfg_data[15:0];
        bdh_pkg::RegInvertLevel:   invert_level   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign in_stall = skid_valid;
  assign in_acc   = in_valid && !in_stall;
  assign out_take = out_valid && !out_stall;

  assign active   = pin_level ^ invert_level;
  assign db_inc   = bdh_pkg::sat_inc(debounce_count);
  assign hold_inc = bdh_pkg::sat_inc(hold_count);
  // widen both sides so any count width compares against the 16-bit registers
  assign db_done   = 33'(db_inc) >= 33'(debounce_ticks);
  assign hold_done = (hold_ticks != 16'd0) && (33'(hold_inc) >= 33'(hold_ticks));

  always_comb begin
    state_next          = state;
    debounce_count_next = debounce_count;
    hold_count_next     = hold_inc;
    pressed_flag_next   = pressed_flag;
    ev                  = bdh_pkg::EV_NONE;
    unique case (state)
      bdh_pkg::ST_IDLE: begin
        if (active) begin
          debounce_count_next = '0;
          state_next          = bdh_pkg::ST_PRESS_DB;
        end
      end
      bdh_pkg::ST_PRESS_DB: begin
        if (!active) begin
          state_next = bdh_pkg::ST_IDLE;
        end else begin
          debounce_count_next = db_inc;
          if (db_done) begin
            state_next        = bdh_pkg::ST_PRESSED;
            pressed_flag_next = 1'b1;
            ev                = bdh_pkg::EV_PRESSED;
            hold_count_next   = '0;
          end
        end
      end
      bdh_pkg::ST_PRESSED: begin
        if (!active) begin
          debounce_count_next = '0;
          state_next          = bdh_pkg::ST_RELEASE_DB;
        end else if (hold_done) begin
          state_next = bdh_pkg::ST_HELD;
          ev         = bdh_pkg::EV_HELD;
        end
      end
      bdh_pkg::ST_HELD: begin
        if (!active) begin
          debounce_count_next = '0;
          state_next          = bdh_pkg::ST_RELEASE_DB;
        end
      end
      bdh_pkg::ST_RELEASE_DB: begin
        if (active) begin
          // glitch: back to pressed, hold timer keeps running
          state_next = bdh_pkg::ST_PRESSED;
        end else begin
          debounce_count_next = db_inc;
          if (db_done) begin
            state_next        = bdh_pkg::ST_IDLE;
            pressed_flag_next = 1'b0;
            ev                = bdh_pkg::EV_RELEASED;
          end
        end
      end
      default: state_next = bdh_pkg::ST_IDLE;
    endcase
    result.ev      = ev;
    result.pressed = pressed_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= bdh_pkg::ST_IDLE;
      debounce_count <= '0;
      hold_count     <= '0;
      pressed_flag   <= 1'b0;
    end else if (in_acc) begin
      state          <= state_next;
      debounce_count <= debounce_count_next;
      hold_count     <= hold_count_next;
      pressed_flag   <= pressed_flag_next;
    end
  end

  // output register with one skid word behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_take || !out_valid) begin
      out_valid  <= skid_valid || in_acc;
      skid_valid <= 1'b0;
    end else if (in_acc) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_take || !out_valid) begin
      out_word <= skid_valid ? skid_word : result;
    end else if (in_acc) begin
      skid_word <= result;
    end
  end

  assign event_code = out_word.ev;
  assign btn_down   = out_word.pressed;

endmodule

// File: src/bdh_checker.sv
`include "button_debounce_hold_detector_macros.svh"

module bdh_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [1:0]                    event_code,
  input logic                          btn_down
);

  logic press_or_held, released;

  assign press_or_held = (event_code == bdh_pkg::EV_PRESSED) ||
                         (event_code == bdh_pkg::EV_HELD);
  assign released      = (event_code == bdh_pkg::EV_RELEASED);

  // a stalled word stays put
  `BDH_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(event_code) && $stable(btn_down))
  // press and held events come with the flag set
  `BDH_ASSERT(a_press_flag, out_valid && press_or_held |-> btn_down)
  // release event comes with the flag cleared
  `BDH_ASSERT(a_release_flag, out_valid && released |-> !btn_down)
  // input backpressure only when a stalled word is already waiting
  `BDH_ASSERT(a_stall_cause, in_stall |-> $past(out_valid && out_stall))
  // reset empties the output side
  `BDH_ASSERT_RST(a_reset_empty, rst |=> !out_valid && !in_stall)

endmodule

bind button_debounce_hold_detector bdh_checker u_bdh_checker (.*);

// File: tb/button_debounce_hold_detector_tb.sv
module button_debounce_hold_detector_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [bdh_pkg::CfgIndexW-1:0] RegUnused = 2'd3;
  localparam int StallLimit = 4000;
  localparam int LongHoldCycles = 300;

  typedef enum {RX_FREE, RX_COIN, RX_HEAVY, RX_PERIODIC} rx_mode_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [bdh_pkg::CfgIndexW-1:0] cfg_index = '0;
  logic [bdh_pkg::CfgWidth-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic pin_level = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] event_code;
  logic btn_down;

  // sequencing flag, written by the stimulus process only
  logic send_pause = 1'b0;

  logic pin_ticks[$];
  bdh_pkg::result_t expected_events[$];

  // predictor configuration and state
  logic [15:0] mdl_db = bdh_pkg::DebounceTicksReset;
  logic [15:0] mdl_hold = bdh_pkg::HoldTicksReset;
  logic mdl_inv = 1'b0;
  bdh_pkg::state_t btn_state = bdh_pkg::ST_IDLE;
  logic [bdh_pkg::CountWidth-1:0] db_cnt = '0;
  logic [bdh_pkg::CountWidth-1:0] hold_cnt = '0;
  logic pressed_m = 1'b0;

  int burst_left = 0;
  int gap_left = 0;
  int ticks_sent = 0;
  int rx_left = 0;
  int rx_phase = 0;
  int rx_count = 0;
  int rx_hold_left = 0;
  bit long_hold_done = 1'b0;
  rx_mode_t rx_mode = RX_FREE;
  int idle_cycles = 0;
  int fail_count = 0;
  int results_seen = 0;
  int n_pressed = 0;
  int n_held = 0;
  int n_released = 0;
  int settings_count = 0;
  bdh_pkg::result_t want;

  button_debounce_hold_detector DUT (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .pin_level(pin_level),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .event_code(event_code),
    .btn_down(btn_down)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [bdh_pkg::CountWidth-1:0] bump(
      input logic [bdh_pkg::CountWidth-1:0] v);
    logic [bdh_pkg::CountWidth:0] w;
    w = {1'b0, v} + 1'b1;
    return w[bdh_pkg::CountWidth] ? v : w[bdh_pkg::CountWidth-1:0];
  endfunction

  task automatic predict_tick(input logic pin);
    logic act;
    bdh_pkg::event_t ev;
    bdh_pkg::result_t r;
    act = mdl_inv ? ~pin : pin;
    ev = bdh_pkg::EV_NONE;
    hold_cnt = bump(hold_cnt);
    case (btn_state)
      bdh_pkg::ST_IDLE: begin
        if (act) begin
          db_cnt = '0;
          btn_state = bdh_pkg::ST_PRESS_DB;
        end
      end
      bdh_pkg::ST_PRESS_DB: begin
        if (!act) begin
          btn_state = bdh_pkg::ST_IDLE;
        end else begin
          db_cnt = bump(db_cnt);
          if (db_cnt >= mdl_db) begin
            btn_state = bdh_pkg::ST_PRESSED;
            pressed_m = 1'b1;
            ev = bdh_pkg::EV_PRESSED;
            hold_cnt = '0;
          end
        end
      end
      bdh_pkg::ST_PRESSED: begin
        if (!act) begin
          db_cnt = '0;
          btn_state = bdh_pkg::ST_RELEASE_DB;
        end else if (mdl_hold != 0 && hold_cnt >= mdl_hold) begin
          btn_state = bdh_pkg::ST_HELD;
          ev = bdh_pkg::EV_HELD;
        end
      end
      bdh_pkg::ST_HELD: begin
        if (!act) begin
          db_cnt = '0;
          btn_state = bdh_pkg::ST_RELEASE_DB;
        end
      end
      bdh_pkg::ST_RELEASE_DB: begin
        // bounce back keeps the running hold count
        if (act) begin
          btn_state = bdh_pkg::ST_PRESSED;
        end else begin
          db_cnt = bump(db_cnt);
          if (db_cnt >= mdl_db) begin
            btn_state = bdh_pkg::ST_IDLE;
            pressed_m = 1'b0;
            ev = bdh_pkg::EV_RELEASED;
          end
        end
      end
      default: btn_state = bdh_pkg::ST_IDLE;
    endcase
    r.ev = ev;
    r.pressed = pressed_m;
    expected_events.push_back(r);
  endtask

  // driver: one tick word per handshake, bursts with gaps
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_tick(pin_level);
        void'(pin_ticks.pop_front());
        ticks_sent++;
      end
      if (!(in_valid && in_stall)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pin_ticks.size() > 0 && !send_pause) begin
          in_valid <= 1'b1;
          pin_level <= pin_ticks[0];
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
            if ($urandom_range(0, 3) == 0)
              gap_left = 0;
            else if ($urandom_range(0, 9) == 0)
              gap_left = $urandom_range(10, 30);
            else
              gap_left = $urandom_range(1, 3);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall pattern, with one long hold-off once traffic is going
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall)
        rx_count++;
      if (!long_hold_done && rx_count >= 400 && in_valid) begin
        long_hold_done = 1'b1;
        rx_hold_left = LongHoldCycles;
      end
      if (rx_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        rx_left = $urandom_range(10, 80);
      end else begin
        rx_left--;
      end
      rx_phase++;
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        out_stall <= 1'b1;
      end else begin
        case (rx_mode)
          RX_FREE: out_stall <= 1'b0;
          RX_COIN: out_stall <= 1'($urandom_range(0, 1));
          RX_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= (rx_phase % 3 == 0);
        endcase
      end
    end
  end

  // monitor: compare each result word with the oldest prediction
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      case (event_code)
        bdh_pkg::EV_PRESSED: n_pressed++;
        bdh_pkg::EV_HELD: n_held++;
        bdh_pkg::EV_RELEASED: n_released++;
        default: ;
      endcase
      if (expected_events.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected result word: event %0d pressed %0b", event_code, btn_down);
      end else begin
        want = expected_events.pop_front();
        if (event_code !== want.ev || btn_down !== want.pressed) begin
          fail_count++;
          if (fail_count <= 10)
            $display("result %0d: event exp %0d got %0d, pressed exp %0b got %0b",
                     results_seen, want.ev, event_code, want.pressed, btn_down);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= StallLimit) begin
        $display("no handshake for %0d cycles, %0d results outstanding",
                 StallLimit, expected_events.size());
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [bdh_pkg::CfgIndexW-1:0] idx,
                           input logic [bdh_pkg::CfgWidth-1:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      bdh_pkg::RegDebounceTicks: mdl_db = val;
      bdh_pkg::RegHoldTicks: mdl_hold = val;
      bdh_pkg::RegInvertLevel: mdl_inv = val[0];
      default: ;
    endcase
    settings_count++;
  endtask

  task automatic drain();
    @(negedge clk);
    while (pin_ticks.size() != 0 || in_valid || expected_events.size() != 0)
      @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic push_active(input logic act, input int count);
    repeat (count) pin_ticks.push_back(act ^ mdl_inv);
  endtask

  task automatic push_bits(input logic [31:0] bits, input int n);
    for (int i = n - 1; i >= 0; i--)
      pin_ticks.push_back(bits[i]);
  endtask

  // bounce in, stable press (or a short one), bounce out, stable release
  task automatic add_press();
    int db;
    int hl;
    int n;
    db = mdl_db;
    hl = (mdl_hold > 30) ? 30 : mdl_hold;
    n = $urandom_range(0, 3);
    repeat (n) begin
      push_active(1'b1, $urandom_range(1, db + 1));
      push_active(1'b0, $urandom_range(1, 2));
    end
    if ($urandom_range(0, 4) == 0)
      push_active(1'b1, $urandom_range(0, db + 1));
    else
      push_active(1'b1, $urandom_range(db + 1, db + hl + 6));
    n = $urandom_range(0, 3);
    repeat (n) begin
      push_active(1'b0, $urandom_range(1, db + 1));
      push_active(1'b1, $urandom_range(1, 2));
    end
    push_active(1'b0, $urandom_range(db + 1, db + 8));
  endtask

  initial begin
    int added;
    int base;
    logic [15:0] db;
    logic [15:0] hl;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // register defaults straight out of reset
    @(negedge clk);
    repeat (3) add_press();
    drain();

    // directed: press glitch, press, held, release glitch, held again, release
    write_reg(bdh_pkg::RegDebounceTicks, 16'd1);
    write_reg(bdh_pkg::RegHoldTicks, 16'd3);
    write_reg(bdh_pkg::RegInvertLevel, 16'hFFFE);
    write_reg(RegUnused, 16'hFFFF);
    @(negedge clk);
    push_bits(32'b001011111011000, 15);
    drain();
    // inverted, zero debounce, hold of one tick
    write_reg(bdh_pkg::RegDebounceTicks, 16'd0);
    write_reg(bdh_pkg::RegHoldTicks, 16'd1);
    write_reg(bdh_pkg::RegInvertLevel, 16'hFFFF);
    @(negedge clk);
    push_bits(32'b1100011011, 10);
    drain();

    for (int p = 0; p < 10; p++) begin
      if (p == 0) begin
        db = 16'd0;
        hl = 16'd0;
      end else if (p == 1) begin
        db = 16'd0;
        hl = 16'd1;
      end else begin
        db = 16'($urandom_range(0, 6));
        hl = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(1, 25));
      end
      write_reg(bdh_pkg::RegDebounceTicks, db);
      write_reg(bdh_pkg::RegHoldTicks, hl);
      write_reg(bdh_pkg::RegInvertLevel, 16'($urandom_range(0, 16'hFFFF)));
      if (p == 5)
        write_reg(RegUnused, 16'($urandom_range(0, 16'hFFFF)));
      @(negedge clk);
      added = 0;
      while (added < 80) begin
        base = pin_ticks.size();
        if ($urandom_range(0, 4) == 0) begin
          repeat ($urandom_range(1, 12)) pin_ticks.push_back(1'($urandom_range(0, 1)));
        end else begin
          add_press();
        end
        added += pin_ticks.size() - base;
      end
      // leave the button released before the next setting
      push_active(1'b0, mdl_db + 2);
      if (p == 4) begin
        while (pin_ticks.size() > 60) @(negedge clk);
        send_pause <= 1'b1;
        @(negedge clk);
        while (expected_events.size() != 0 || in_valid) @(negedge clk);
        send_pause <= 1'b0;
      end
      drain();
    end

    // widest debounce: a short press never confirms
    write_reg(bdh_pkg::RegInvertLevel, 16'h0000);
    write_reg(bdh_pkg::RegDebounceTicks, 16'hFFFF);
    write_reg(bdh_pkg::RegHoldTicks, 16'h0000);
    @(negedge clk);
    push_active(1'b0, 4);
    push_active(1'b1, 40);
    push_active(1'b0, 4);
    drain();

    repeat (5) @(posedge clk);
    $display("%0d ticks over %0d register writes, %0d result words checked",
             ticks_sent, settings_count, results_seen);
    $display("events seen: %0d pressed, %0d held, %0d released; %0d mismatches",
             n_pressed, n_held, n_released, fail_count);
    if (fail_count == 0 && expected_events.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
